FILE: hdl/almw_pkg.sv
package almw_pkg;

  localparam int unsigned PART_CHARS = 4;
  localparam int unsigned KEY_CHARS  = 4;

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_VT    = 8'd11;
  localparam logic [7:0] CHAR_FF    = 8'd12;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_A    = 2'd1,
    KIND_C    = 2'd2
  } line_kind_e;

  typedef enum logic [1:0] {
    SEC_DEST = 2'd0,
    SEC_COMP = 2'd1,
    SEC_JUMP = 2'd2
  } section_e;

  typedef struct packed {
    line_kind_e  kind;
    logic        equals_seen;
    section_e    section;
    logic        negative;
    logic [14:0] address;
  } line_ctrl_t;

  // {hit, code}
  function automatic logic [7:0] comp_lookup(logic [31:0] key);
    logic [7:0] r;
    r = 8'h00;
    case (key)
      32'("0"):   r = {1'b1, 7'h2A};
      32'("1"):   r = {1'b1, 7'h3F};
      32'("-1"):  r = {1'b1, 7'h3A};
      32'("D"):   r = {1'b1, 7'h0C};
      32'("A"):   r = {1'b1, 7'h30};
      32'("!D"):  r = {1'b1, 7'h0D};
      32'("!A"):  r = {1'b1, 7'h31};
      32'("-D"):  r = {1'b1, 7'h0F};
      32'("-A"):  r = {1'b1, 7'h33};
      32'("D+1"): r = {1'b1, 7'h1F};
      32'("1+D"): r = {1'b1, 7'h1F};
      32'("A+1"): r = {1'b1, 7'h37};
      32'("1+A"): r = {1'b1, 7'h37};
      32'("D-1"): r = {1'b1, 7'h0E};
      32'("A-1"): r = {1'b1, 7'h32};
      32'("D+A"): r = {1'b1, 7'h02};
      32'("D-A"): r = {1'b1, 7'h13};
      32'("A-D"): r = {1'b1, 7'h07};
      32'("D&A"): r = {1'b1, 7'h00};
      32'("D|A"): r = {1'b1, 7'h15};
      32'("M"):   r = {1'b1, 7'h70};
      32'("!M"):  r = {1'b1, 7'h71};
      32'("-M"):  r = {1'b1, 7'h73};
      32'("M+1"): r = {1'b1, 7'h77};
      32'("1+M"): r = {1'b1, 7'h77};
      32'("M-1"): r = {1'b1, 7'h72};
      32'("D+M"): r = {1'b1, 7'h42};
      32'("M+D"): r = {1'b1, 7'h42};
      32'("D-M"): r = {1'b1, 7'h53};
      32'("M-D"): r = {1'b1, 7'h47};
      32'("D&M"): r = {1'b1, 7'h40};
      32'("M&D"): r = {1'b1, 7'h40};
      32'("D|M"): r = {1'b1, 7'h55};
      32'("M|D"): r = {1'b1, 7'h55};
      default:    r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] dest_lookup(logic [31:0] key);
    logic [3:0] r;
    r = 4'h0;
    case (key)
      32'("null"): r = {1'b1, 3'd0};
      32'("M"):    r = {1'b1, 3'd1};
      32'("D"):    r = {1'b1, 3'd2};
      32'("MD"):   r = {1'b1, 3'd3};
      32'("A"):    r = {1'b1, 3'd4};
      32'("AM"):   r = {1'b1, 3'd5};
      32'("AD"):   r = {1'b1, 3'd6};
      32'("AMD"):  r = {1'b1, 3'd7};
      default:     r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] jump_lookup(logic [31:0] key);
    logic [3:0] r;
    r = 4'h0;
    case (key)
      32'("null"): r = {1'b1, 3'd0};
      32'("JGT"):  r = {1'b1, 3'd1};
      32'("JEQ"):  r = {1'b1, 3'd2};
      32'("JGE"):  r = {1'b1, 3'd3};
      32'("JLT"):  r = {1'b1, 3'd4};
      32'("JNE"):  r = {1'b1, 3'd5};
      32'("JLE"):  r = {1'b1, 3'd6};
      32'("JMP"):  r = {1'b1, 3'd7};
      default:     r = 4'h0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/almw_line_parser.sv
module almw_line_parser #(
  parameter int unsigned PartChars = almw_pkg::PART_CHARS,
  localparam int unsigned LenW = $clog2(PartChars + 2)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic [7:0]                         byte_i,
  output logic                               emit_o,
  output almw_pkg::line_ctrl_t               ctrl_o,
  output logic [2:0][PartChars-1:0][7:0]     text_o,
  output logic [2:0][LenW-1:0]               len_o
);
  import almw_pkg::*;

  line_kind_e                   kind_q, kind_d, kind_eff;
  logic                         comment_q, comment_d;
  section_e                     sec_q, sec_d;
  logic                         equals_q, equals_d;
  logic [14:0]                  addr_q, addr_d;
  logic                         neg_q, neg_d;
  logic                         ended_q, ended_d;
  logic                         first_q, first_d;
  logic [2:0][LenW-1:0]         len_q, len_d;
  logic [2:0][PartChars-1:0][7:0] text_q;
  logic                         add_en;
  logic                         is_nl, is_ws, is_cmt, is_digit;

  assign is_nl    = (byte_i == CHAR_NL);
  assign is_ws    = (byte_i == CHAR_TAB) || (byte_i == CHAR_VT) || (byte_i == CHAR_FF) ||
                    (byte_i == CHAR_CR) || (byte_i == CHAR_SPACE);
  assign is_cmt   = (byte_i == CHAR_SLASH) || (byte_i == CHAR_NUL);
  assign is_digit = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign kind_eff = (kind_q == KIND_NONE) ? KIND_C : kind_q;

  always_comb begin
    kind_d    = kind_q;
    comment_d = comment_q;
    sec_d     = sec_q;
    equals_d  = equals_q;
    addr_d    = addr_q;
    neg_d     = neg_q;
    ended_d   = ended_q;
    first_d   = first_q;
    len_d     = len_q;
    add_en    = 1'b0;
    if (step_i) begin
      if (is_nl) begin
        kind_d    = KIND_NONE;
        comment_d = 1'b0;
        sec_d     = SEC_DEST;
        equals_d  = 1'b0;
        addr_d    = '0;
        neg_d     = 1'b0;
        ended_d   = 1'b0;
        first_d   = 1'b1;
        len_d     = '0;
      end else if (!comment_q && !is_ws) begin
        if (is_cmt) begin
          comment_d = 1'b1;
        end else if (kind_q == KIND_NONE && byte_i == CHAR_AT) begin
          kind_d = KIND_A;
        end else begin
          kind_d = kind_eff;
          if (kind_eff == KIND_A) begin
            first_d = 1'b0;
            if (!ended_q) begin
              if (first_q && (byte_i == CHAR_PLUS || byte_i == CHAR_MINUS)) begin
                neg_d = (byte_i == CHAR_MINUS);
              end else if (is_digit) begin
                addr_d = addr_q * 15'd10 + {11'd0, byte_i[3:0]};
              end else begin
                ended_d = 1'b1;
              end
            end
          end else if (byte_i == CHAR_EQ && sec_q == SEC_DEST) begin
            equals_d = 1'b1;
            sec_d    = SEC_COMP;
          end else if (byte_i == CHAR_SEMI && sec_q != SEC_JUMP) begin
            sec_d = SEC_JUMP;
          end else begin
            add_en = 1'b1;
          end
        end
      end
    end
    if (add_en) begin
      for (int p = 0; p < 3; p++) begin
        if (sec_q == section_e'(p) && len_q[p] <= LenW'(PartChars)) begin
          len_d[p] = len_q[p] + LenW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= KIND_NONE;
      comment_q <= 1'b0;
      sec_q     <= SEC_DEST;
      equals_q  <= 1'b0;
      addr_q    <= '0;
      neg_q     <= 1'b0;
      ended_q   <= 1'b0;
      first_q   <= 1'b1;
      len_q     <= '0;
    end else begin
      kind_q    <= kind_d;
      comment_q <= comment_d;
      sec_q     <= sec_d;
      equals_q  <= equals_d;
      addr_q    <= addr_d;
      neg_q     <= neg_d;
      ended_q   <= ended_d;
      first_q   <= first_d;
      len_q     <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_en) begin
      for (int p = 0; p < 3; p++) begin
        for (int i = 0; i < int'(PartChars); i++) begin
          if (sec_q == section_e'(p) && len_q[p] == LenW'(i)) begin
            text_q[p][i] <= byte_i;
          end
        end
      end
    end
  end

  assign emit_o = is_nl && (kind_q != KIND_NONE);

  always_comb begin
    ctrl_o.kind        = kind_q;
    ctrl_o.equals_seen = equals_q;
    ctrl_o.section     = sec_q;
    ctrl_o.negative    = neg_q;
    ctrl_o.address     = addr_q;
  end

  assign text_o = text_q;
  assign len_o  = len_q;

endmodule

FILE: hdl/almw_encoder.sv
module almw_encoder #(
  parameter int unsigned PartChars = almw_pkg::PART_CHARS,
  localparam int unsigned LenW = $clog2(PartChars + 2)
) (
  input  almw_pkg::line_ctrl_t               ctrl_i,
  input  logic [2:0][PartChars-1:0][7:0]     text_i,
  input  logic [2:0][LenW-1:0]               len_i,
  output logic [15:0]                        word_o,
  output logic                               invalid_o
);
  import almw_pkg::*;

  logic [2:0][31:0] key;
  logic [2:0]       fits;
  logic [7:0]       comp_r;
  logic [3:0]       dest_r, jump_r;
  logic             comp_hit, dest_hit, jump_hit;
  logic [14:0]      addr_val;

  // right-align the part text so it matches a string literal
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      key[p] = '0;
      for (int i = 0; i < int'(KEY_CHARS); i++) begin
        if (LenW'(i) < len_i[p]) begin
          key[p] = {key[p][23:0], text_i[p][i]};
        end
      end
      fits[p] = (len_i[p] <= LenW'(KEY_CHARS));
    end
  end

  always_comb begin
    if (ctrl_i.equals_seen) begin
      dest_r   = dest_lookup(key[0]);
      dest_hit = dest_r[3] && fits[0];
      comp_r   = comp_lookup(key[1]);
      comp_hit = comp_r[7] && fits[1];
    end else begin
      dest_r   = 4'h8;
      dest_hit = 1'b1;
      comp_r   = comp_lookup(key[0]);
      comp_hit = comp_r[7] && fits[0];
    end
    if (ctrl_i.section == SEC_JUMP) begin
      jump_r   = jump_lookup(key[2]);
      jump_hit = jump_r[3] && fits[2];
    end else begin
      jump_r   = 4'h8;
      jump_hit = 1'b1;
    end
  end

  assign addr_val = ctrl_i.negative ? (15'd0 - ctrl_i.address) : ctrl_i.address;

  always_comb begin
    word_o    = '0;
    invalid_o = 1'b0;
    if (ctrl_i.kind == KIND_A) begin
      word_o = {1'b0, addr_val};
    end else if (comp_hit && dest_hit && jump_hit) begin
      word_o = {3'b111, comp_r[6:0], dest_r[2:0], jump_r[2:0]};
    end else begin
      invalid_o = 1'b1;
    end
  end

endmodule

FILE: hdl/asm_line_to_machine_word_unit.sv
// Hack assembly line encoder.
// Slave stream: one ASCII byte of source text per request on s_axis_tdata_i.
// Whitespace is dropped, '/' or NUL drops the rest of the line, byte 10 ends
// the line. A line opening with '@' yields an address word; any other
// non-blank line is decoded as dest=comp;jump. Blank lines yield nothing.
// Master stream: one request per non-blank line, tdata = machine word,
// tuser = invalid flag (word is zero when set).
// Throughput: one byte per cycle unless a newline waits for the result
// register; set by the per-byte line-state update between the input and
// result registers. A line's result passes from the input register, which
// holds its newline, to the result register, which drives the master side.
// Reset clears line state and both valid flags; nothing is pending after it.
// When the master side stalls, the result holds and one more byte may wait
// in the input register; bytes that produce no result keep flowing, a
// newline that produces one waits until the result register frees.
module asm_line_to_machine_word_unit #(
  parameter int unsigned PartChars = almw_pkg::PART_CHARS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] machine_word
  output logic        m_axis_tuser_o    // [0] invalid
);
  import almw_pkg::*;

  localparam int unsigned LenW = $clog2(PartChars + 2);

  logic                           in_valid_q;
  logic [7:0]                     in_byte_q;
  logic                           out_valid_q;
  logic [15:0]                    out_word_q;
  logic                           out_invalid_q;
  logic                           out_free, consume, emit;
  line_ctrl_t                     ctrl;
  logic [2:0][PartChars-1:0][7:0] text;
  logic [2:0][LenW-1:0]           len;
  logic [15:0]                    word;
  logic                           invalid;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign consume         = in_valid_q && (!emit || out_free);
  assign s_axis_tready_o = !in_valid_q || consume;

  almw_line_parser #(.PartChars(PartChars)) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (consume),
    .byte_i (in_byte_q),
    .emit_o (emit),
    .ctrl_o (ctrl),
    .text_o (text),
    .len_o  (len)
  );

  almw_encoder #(.PartChars(PartChars)) u_encoder (
    .ctrl_i    (ctrl),
    .text_i    (text),
    .len_i     (len),
    .word_o    (word),
    .invalid_o (invalid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (consume && emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (consume && emit) begin
      out_word_q    <= word;
      out_invalid_q <= invalid;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_word_q;
  assign m_axis_tuser_o  = out_invalid_q;

endmodule

FILE: tb/sv/asm_line_to_machine_word_unit_tb.sv
`timescale 1ns / 1ps

module asm_line_to_machine_word_unit_tb;
  import almw_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned RANDOM_BYTES = 400;

  typedef struct packed {
    logic [15:0] word;
    logic        bad;
  } hack_word_t;

  class hack_word_scoreboard;
    string      comp_key[34];
    logic [6:0] comp_val[34];
    string      dest_key[8];
    string      jump_key[8];
    logic [6:0] comp_code[string];
    logic [2:0] dest_code[string];
    logic [2:0] jump_code[string];
    hack_word_t pending_words[$];

    line_kind_e  kind;
    bit          skip_rest;
    section_e    sect;
    bit          split_eq;
    logic [7:0]  part_c[3][PART_CHARS];
    int unsigned part_len[3];
    logic [14:0] addr;
    bit          neg;
    bit          digits_done;
    bit          at_first;

    int unsigned n_bytes, n_words, n_a, n_c, n_bad, errors;

    function new();
      comp_key = '{"0", "1", "-1", "D", "A", "!D", "!A", "-D", "-A", "D+1", "1+D", "A+1",
                   "1+A", "D-1", "A-1", "D+A", "D-A", "A-D", "D&A", "D|A", "M", "!M", "-M",
                   "M+1", "1+M", "M-1", "D+M", "M+D", "D-M", "M-D", "D&M", "M&D", "D|M",
                   "M|D"};
      comp_val = '{7'h2A, 7'h3F, 7'h3A, 7'h0C, 7'h30, 7'h0D, 7'h31, 7'h0F, 7'h33, 7'h1F,
                   7'h1F, 7'h37, 7'h37, 7'h0E, 7'h32, 7'h02, 7'h13, 7'h07, 7'h00, 7'h15,
                   7'h70, 7'h71, 7'h73, 7'h77, 7'h77, 7'h72, 7'h42, 7'h42, 7'h53, 7'h47,
                   7'h40, 7'h40, 7'h55, 7'h55};
      dest_key = '{"null", "M", "D", "MD", "A", "AM", "AD", "AMD"};
      jump_key = '{"null", "JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};
      foreach (comp_key[i]) comp_code[comp_key[i]] = comp_val[i];
      foreach (dest_key[i]) dest_code[dest_key[i]] = 3'(i);
      foreach (jump_key[i]) jump_code[jump_key[i]] = 3'(i);
      clear_line();
    endfunction

    function void clear_line();
      kind        = KIND_NONE;
      skip_rest   = 1'b0;
      sect        = SEC_DEST;
      split_eq    = 1'b0;
      foreach (part_c[p, i]) part_c[p][i] = 8'h00;
      foreach (part_len[p]) part_len[p] = 0;
      addr        = '0;
      neg         = 1'b0;
      digits_done = 1'b0;
      at_first    = 1'b1;
    endfunction

    function string part_key(int p);
      string s;
      s = "";
      if (part_len[p] > PART_CHARS) return s;
      for (int i = 0; i < part_len[p]; i++) s = $sformatf("%s%c", s, part_c[p][i]);
      return s;
    endfunction

    function hack_word_t close_line();
      hack_word_t w;
      string dk, ck, jk;
      w.bad = 1'b0;
      if (kind == KIND_A) begin
        w.word = {1'b0, neg ? (15'd0 - addr) : addr};
        return w;
      end
      if (split_eq) begin
        dk = part_key(0);
        ck = part_key(1);
      end else begin
        dk = "null";
        ck = part_key(0);
      end
      if (sect == SEC_JUMP) jk = part_key(2);
      else jk = "null";
      if (comp_code.exists(ck) && dest_code.exists(dk) && jump_code.exists(jk)) begin
        w.word = {3'b111, comp_code[ck], dest_code[dk], jump_code[jk]};
      end else begin
        w.word = '0;
        w.bad  = 1'b1;
      end
      return w;
    endfunction

    function void note_text_byte(logic [7:0] c);
      hack_word_t w;
      bit lead;
      n_bytes++;
      if (c == CHAR_NL) begin
        if (kind != KIND_NONE) begin
          w = close_line();
          if (kind == KIND_A) n_a++;
          else if (w.bad) n_bad++;
          else n_c++;
          pending_words.push_back(w);
        end
        clear_line();
        return;
      end
      if (skip_rest || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF || c == CHAR_CR ||
          c == CHAR_SPACE) return;
      if (c == CHAR_SLASH || c == CHAR_NUL) begin
        skip_rest = 1'b1;
        return;
      end
      if (kind == KIND_NONE) begin
        if (c == CHAR_AT) begin
          kind = KIND_A;
          return;
        end
        kind = KIND_C;
      end
      if (kind == KIND_A) begin
        lead     = at_first;
        at_first = 1'b0;
        if (!digits_done) begin
          if (lead && (c == CHAR_PLUS || c == CHAR_MINUS)) neg = (c == CHAR_MINUS);
          else if (c >= CHAR_ZERO && c <= CHAR_NINE) addr = 15'(addr * 10 + (c - CHAR_ZERO));
          else digits_done = 1'b1;
        end
        return;
      end
      if (c == CHAR_EQ && sect == SEC_DEST) begin
        split_eq = 1'b1;
        sect     = SEC_COMP;
      end else if (c == CHAR_SEMI && sect != SEC_JUMP) begin
        sect = SEC_JUMP;
      end else begin
        if (part_len[sect] < PART_CHARS) part_c[sect][part_len[sect]] = c;
        if (part_len[sect] <= PART_CHARS) part_len[sect]++;
      end
    endfunction

    function void check_word(logic [15:0] word, logic bad);
      hack_word_t w;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h invalid %b", $time, word, bad);
        return;
      end
      w = pending_words.pop_front();
      n_words++;
      if (w.word !== word) begin
        errors++;
        $display("%0t: machine word expected %h got %h", $time, w.word, word);
      end
      if (w.bad !== bad) begin
        errors++;
        $display("%0t: invalid flag expected %b got %b", $time, w.bad, bad);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  hack_word_scoreboard sb = new();
  logic [7:0]  text_q[$];
  int unsigned bytes_sent;
  int unsigned idle_cycles;
  bit          calm;
  bit          hold_req;

  asm_line_to_machine_word_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 4))
      0:       return CHAR_TAB;
      1:       return CHAR_VT;
      2:       return CHAR_FF;
      3:       return CHAR_CR;
      default: return CHAR_SPACE;
    endcase
  endfunction

  function automatic void put(string s);
    foreach (s[i]) text_q.push_back(s[i]);
  endfunction

  function automatic void put_loose(string s);
    foreach (s[i]) begin
      if ($urandom_range(0, 7) == 0) text_q.push_back(blank_byte());
      text_q.push_back(s[i]);
    end
  endfunction

  function automatic void put_c_line(int unsigned turn);
    int unsigned d, j;
    d = $urandom_range(0, 8);
    j = $urandom_range(0, 8);
    if (d < 8) begin
      put_loose(sb.dest_key[d]);
      put_loose("=");
    end
    put_loose(sb.comp_key[turn % 34]);
    if (j < 8) begin
      put_loose(";");
      put_loose(sb.jump_key[j]);
    end
    if ($urandom_range(0, 5) == 0) put(" // loop");
  endfunction

  function automatic void put_a_line();
    put_loose("@");
    case ($urandom_range(0, 3))
      0:       put("+");
      1:       put("-");
      default: ;
    endcase
    repeat ($urandom_range(0, 6)) text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 4) == 0) begin
      put_loose("x");
      repeat ($urandom_range(0, 2)) text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endfunction

  function automatic void put_broken_line(int unsigned turn);
    int unsigned idx;
    put_c_line(turn);
    idx = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 2))
      0:       text_q[idx] = 8'($urandom_range(0, 255));
      1:       text_q.insert(idx, $urandom_range(0, 1) ? CHAR_EQ : CHAR_SEMI);
      default: put("XY");
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i]);
    text_q.delete();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_word(m_axis_tdata_o, m_axis_tuser_o);
      if (s_axis_tvalid_i && s_axis_tready_o) sb.note_text_byte(s_axis_tdata_i);
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned stall;
    m_axis_tready_i <= 1'b0;
    stall = pick_gap();
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) stall = pick_gap();
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        stall--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned turn, calm_lines, next_hold, pick, goal;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    idle_cycles     = 0;
    bytes_sent      = 0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    turn            = $urandom_range(0, 33);
    calm_lines      = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put("@-1\n");
    put("@99999\n");
    put("=D\n");
    put("D;\n");
    put("AMD=D|M;JMP\n");
    put("\n");
    put("A=1/x\n");
    text_q.push_back(8'hFF);
    text_q.push_back(CHAR_NUL);
    put("A\n");
    send_text();

    next_hold = bytes_sent;
    goal      = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < goal) begin
      if (bytes_sent >= next_hold) begin
        hold_req   = 1'b1;
        calm       = 1'b1;
        calm_lines = 6;
        next_hold  = bytes_sent + 250;
      end else if (calm_lines > 0) begin
        calm_lines--;
      end else if ($urandom_range(0, 5) == 0) begin
        calm = !calm;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        put_c_line(turn);
        turn++;
      end else if (pick < 72) begin
        put_a_line();
      end else if (pick < 78) begin
        if ($urandom_range(0, 1)) text_q.push_back(blank_byte());
        if ($urandom_range(0, 1)) put("// x");
      end else if (pick < 92) begin
        put_broken_line(turn);
        turn++;
      end else begin
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      text_q.push_back(CHAR_NL);
      send_text();
    end
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Fed %0d text bytes with two long output stalls; checked %0d words:",
             sb.n_bytes, sb.n_words);
    $display("  %0d address, %0d compute, %0d invalid, %0d mismatches",
             sb.n_a, sb.n_c, sb.n_bad, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
